### rtl/grt_pkg.sv
// Shared constants, font table, decimal weight table and state type for the glyph renderer.
package grt_pkg;

  // Font geometry
  localparam int FONT_COUNT  = 91;
  localparam int GLYPH_WIDTH = 5;
  localparam int FONT_BYTES  = FONT_COUNT * GLYPH_WIDTH;
  localparam int ROM_AW      = $clog2(FONT_BYTES);
  localparam int DEC_DIGITS  = 5;
  localparam int DEC_VALUES  = 10;

  localparam logic [7:0] FONT_FIRST = 8'd32;
  localparam logic [7:0] FONT_LAST  = 8'd122;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] BLANK_COL  = 8'h00;
  localparam logic [2:0] COL_LAST   = 3'(GLYPH_WIDTH);
  localparam logic [2:0] POS_LAST   = 3'(DEC_DIGITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_GLYPH
  } grt_state_t;

  // Multiples k * 10^(4-pos) for k = 0..9, one row per decimal position
  localparam logic [16:0] DEC_MULT [DEC_DIGITS][DEC_VALUES] = '{
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
      17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
    '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
      17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
    '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
      17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
    '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
      17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
    '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4,
      17'd5, 17'd6, 17'd7, 17'd8, 17'd9}
  };

  // 5x8 font, five column bytes per code from 32 up, bit 0 is the top pixel
  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  8'h00, 8'h00, 8'h2f, 8'h00, 8'h00,
    8'h00, 8'h07, 8'h00, 8'h07, 8'h00,  8'h14, 8'h7f, 8'h14, 8'h7f, 8'h14,
    8'h24, 8'h2a, 8'h7f, 8'h2a, 8'h12,  8'h62, 8'h64, 8'h08, 8'h13, 8'h23,
    8'h36, 8'h49, 8'h55, 8'h22, 8'h50,  8'h00, 8'h05, 8'h03, 8'h00, 8'h00,
    8'h00, 8'h1c, 8'h22, 8'h41, 8'h00,  8'h00, 8'h41, 8'h22, 8'h1c, 8'h00,
    8'h14, 8'h08, 8'h3E, 8'h08, 8'h14,  8'h08, 8'h08, 8'h3E, 8'h08, 8'h08,
    8'h00, 8'h00, 8'hA0, 8'h60, 8'h00,  8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
    8'h00, 8'h60, 8'h60, 8'h00, 8'h00,  8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
    8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,  8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
    8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
    8'h00, 8'h36, 8'h36, 8'h00, 8'h00,  8'h00, 8'h56, 8'h36, 8'h00, 8'h00,
    8'h08, 8'h14, 8'h22, 8'h41, 8'h00,  8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
    8'h00, 8'h41, 8'h22, 8'h14, 8'h08,  8'h02, 8'h01, 8'h51, 8'h09, 8'h06,
    8'h32, 8'h49, 8'h59, 8'h51, 8'h3E,  8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C,
    8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,  8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,
    8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,  8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,
    8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,  8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A,
    8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,  8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,
    8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,  8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,
    8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,  8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F,
    8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,  8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,
    8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,  8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,
    8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,  8'h46, 8'h49, 8'h49, 8'h49, 8'h31,
    8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,  8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,
    8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,  8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F,
    8'h63, 8'h14, 8'h08, 8'h14, 8'h63,  8'h07, 8'h08, 8'h70, 8'h08, 8'h07,
    8'h61, 8'h51, 8'h49, 8'h45, 8'h43,  8'h00, 8'h7F, 8'h41, 8'h41, 8'h00,
    8'h55, 8'h2A, 8'h55, 8'h2A, 8'h55,  8'h00, 8'h41, 8'h41, 8'h7F, 8'h00,
    8'h04, 8'h02, 8'h01, 8'h02, 8'h04,  8'h40, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h00, 8'h01, 8'h02, 8'h04, 8'h00,  8'h20, 8'h54, 8'h54, 8'h54, 8'h78,
    8'h7F, 8'h48, 8'h44, 8'h44, 8'h38,  8'h38, 8'h44, 8'h44, 8'h44, 8'h20,
    8'h38, 8'h44, 8'h44, 8'h48, 8'h7F,  8'h38, 8'h54, 8'h54, 8'h54, 8'h18,
    8'h08, 8'h7E, 8'h09, 8'h01, 8'h02,  8'h18, 8'hA4, 8'hA4, 8'hA4, 8'h7C,
    8'h7F, 8'h08, 8'h04, 8'h04, 8'h78,  8'h00, 8'h44, 8'h7D, 8'h40, 8'h00,
    8'h40, 8'h80, 8'h84, 8'h7D, 8'h00,  8'h7F, 8'h10, 8'h28, 8'h44, 8'h00,
    8'h00, 8'h41, 8'h7F, 8'h40, 8'h00,  8'h7C, 8'h04, 8'h18, 8'h04, 8'h78,
    8'h7C, 8'h08, 8'h04, 8'h04, 8'h78,  8'h38, 8'h44, 8'h44, 8'h44, 8'h38,
    8'hFC, 8'h24, 8'h24, 8'h24, 8'h18,  8'h18, 8'h24, 8'h24, 8'h18, 8'hFC,
    8'h7C, 8'h08, 8'h04, 8'h04, 8'h08,  8'h48, 8'h54, 8'h54, 8'h54, 8'h20,
    8'h04, 8'h3F, 8'h44, 8'h40, 8'h20,  8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C,
    8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C,  8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C,
    8'h44, 8'h28, 8'h10, 8'h28, 8'h44,  8'h1C, 8'hA0, 8'hA0, 8'hA0, 8'h7C,
    8'h44, 8'h64, 8'h54, 8'h4C, 8'h44
  };

endpackage

### rtl/grt_if.sv
// Valid/ready channel interfaces for render requests and display columns.
interface grt_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  char_code;
  logic [15:0] number;

  modport source (output valid, output func, output char_code, output number, input ready);
  modport sink   (input valid, input func, input char_code, input number, output ready);
endinterface

interface grt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_byte;
  logic       last;
  logic       unknown_char;

  modport source (output valid, output column_byte, output last, output unknown_char,
                  input ready);
  modport sink   (input valid, input column_byte, input last, input unknown_char,
                  output ready);
endinterface

### rtl/grt_font_rom.sv
// Synchronous font ROM with one registered read port.
module grt_font_rom (
  input  logic                      clk,
  input  logic                      en,
  input  logic [grt_pkg::ROM_AW-1:0] addr,
  output logic [7:0]                data
);
  import grt_pkg::*;

  // Read on enable, hold the last word otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      data <= FONT_ROM[addr];
    end
  end

endmodule

### rtl/glyph_column_text_renderer.sv
// Top level: turns characters and decimal numbers into 6x8 glyph display columns.
//
//   channel | dir | transaction content
//   in_ch   | in  | func, char_code, number
//   out_ch  | out | column_byte, last, unknown_char (one display column)
//
// A character is accepted, then its six columns are issued. A number steps through
// its five decimal positions, skipping leading zeros, and issues six columns per
// printed digit. in_ch.ready is high only while the sequencer is idle.
// Each issued column reaches out_ch through the ROM stage and the output register.
// Reset clears the sequencer and pipeline valid flags; there is no clearing pass.
// A stall on out_ch with a column staged freezes the ROM read, the staging register and issue.
module glyph_column_text_renderer (
  input logic        clk,
  input logic        rst_n,
  grt_in_if.sink     in_ch,
  grt_out_if.source  out_ch
);
  import grt_pkg::*;

  grt_state_t        state_r, state_nxt;
  logic [7:0]        code_r;
  logic [15:0]       rem_r;
  logic [2:0]        pos_r;
  logic              started_r;
  logic              final_r;
  logic [2:0]        col_r;

  logic [9:1]        ge;
  logic [3:0]        digit;
  logic [16:0]       dec_sub;
  logic [15:0]       rem_nxt;
  logic              show_digit;

  logic              known;
  logic [6:0]        font_idx;
  logic [ROM_AW-1:0] rom_addr;
  logic [7:0]        rom_data;

  logic              in_fire;
  logic              adv_out;
  logic              adv1;
  logic              issue;
  logic              iss_blank;
  logic              iss_last;
  logic              iss_unknown;

  logic              s1_valid_r;
  logic              s1_blank_r;
  logic              s1_last_r;
  logic              s1_unknown_r;

  logic              out_valid_r;
  logic [7:0]        col_byte_r;
  logic              last_r;
  logic              unknown_r;

  // Pipeline advance: output register, then ROM stage
  assign adv_out = !out_valid_r || out_ch.ready;
  assign adv1    = !s1_valid_r || adv_out;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Extract one decimal digit: compare the remainder against all multiples
  always_comb begin
    digit = '0;
    for (int k = 1; k < DEC_VALUES; k++) begin
      ge[k] = {1'b0, rem_r} >= DEC_MULT[pos_r][k];
      if (ge[k]) begin
        digit = 4'(k);
      end
    end
    dec_sub    = DEC_MULT[pos_r][digit];
    rem_nxt    = rem_r - dec_sub[15:0];
    show_digit = (digit != '0) || started_r || (pos_r == POS_LAST);
  end

  // Font address of the current column
  always_comb begin
    known    = (code_r >= FONT_FIRST) && (code_r <= FONT_LAST);
    font_idx = 7'(code_r - FONT_FIRST);
    if (known && (col_r != '0)) begin
      rom_addr = ROM_AW'({2'b00, font_idx} * 9'(GLYPH_WIDTH)) + ROM_AW'(col_r)
               - ROM_AW'(1);
    end else begin
      rom_addr = '0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.func ? ST_DIGIT : ST_GLYPH;
        end
      end
      ST_DIGIT: begin
        if (show_digit) begin
          state_nxt = ST_GLYPH;
        end
      end
      ST_GLYPH: begin
        if (adv1 && (col_r == COL_LAST)) begin
          state_nxt = final_r ? ST_IDLE : ST_DIGIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: request ready and column issue
  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_DIGIT: issue       = 1'b0;
      ST_GLYPH: issue       = adv1;
      default:  in_ch.ready = 1'b0;
    endcase
    iss_blank   = (col_r == '0) || !known;
    iss_unknown = !known;
    iss_last    = final_r && (col_r == COL_LAST);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv1) begin
        s1_valid_r <= issue;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Item context: load on accept, step digits, advance column
  always_ff @(posedge clk) begin
    if (in_fire) begin
      code_r    <= in_ch.char_code;
      rem_r     <= in_ch.number;
      pos_r     <= '0;
      started_r <= 1'b0;
      col_r     <= '0;
      final_r   <= !in_ch.func;
    end else if (state_r == ST_DIGIT) begin
      rem_r <= rem_nxt;
      pos_r <= pos_r + 3'd1;
      if (show_digit) begin
        code_r    <= CHAR_ZERO + {4'b0000, digit};
        started_r <= 1'b1;
        final_r   <= (pos_r == POS_LAST);
        col_r     <= '0;
      end
    end else if (issue) begin
      col_r <= col_r + 3'd1;
    end
  end

  grt_font_rom u_font_rom (
    .clk  (clk),
    .en   (adv1),
    .addr (rom_addr),
    .data (rom_data)
  );

  // ROM stage sideband and output register
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_blank_r   <= iss_blank;
      s1_last_r    <= iss_last;
      s1_unknown_r <= iss_unknown;
    end
    if (adv_out) begin
      col_byte_r <= s1_blank_r ? BLANK_COL : rom_data;
      last_r     <= s1_last_r;
      unknown_r  <= s1_unknown_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_byte  = col_byte_r;
  assign out_ch.last         = last_r;
  assign out_ch.unknown_char = unknown_r;

`ifndef NO_ASSERTIONS
  // The final column of an item returns the sequencer to idle
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && iss_last) |=> (state_r == ST_IDLE))
    else $error("last column issued without returning to idle");

  // The units digit is always printed
  a_units_printed: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIGIT) && (pos_r == POS_LAST)) |=> (state_r == ST_GLYPH))
    else $error("units digit skipped");

  // Unknown codes never read font data
  a_unknown_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_unknown_r) |-> s1_blank_r)
    else $error("unknown character column not blanked");

  // A stalled staged column is kept, not overwritten
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv1) |=> (s1_valid_r && $stable(s1_last_r) && $stable(rom_data)))
    else $error("staged column lost under stall");
`endif

endmodule

### tb/glyph_column_text_renderer_tb.sv
// Self-checking testbench for the glyph column text renderer: directed and random render requests.
`timescale 1ns / 100ps

module glyph_column_text_renderer_tb;

  // Request kinds carried in the func field
  localparam logic FN_CHAR   = 1'b0;
  localparam logic FN_NUMBER = 1'b1;

  localparam int CODE_FIRST  = 32;
  localparam int CODE_LAST   = 122;
  localparam int CODE_ZERO   = 48;
  localparam int CELL_COLS   = 6;
  localparam int FONT_WIDTH  = 5;
  localparam int DIGIT_SLOTS = 5;

  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 12;
  localparam int PRINT_LIMIT = 40;

  localparam int DIGIT_WEIGHT [DIGIT_SLOTS] = '{10000, 1000, 100, 10, 1};

  // Expected glyph columns, five per code from the first printable code up
  localparam logic [7:0] GLYPH_COLS [455] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  8'h00, 8'h00, 8'h2f, 8'h00, 8'h00,
    8'h00, 8'h07, 8'h00, 8'h07, 8'h00,  8'h14, 8'h7f, 8'h14, 8'h7f, 8'h14,
    8'h24, 8'h2a, 8'h7f, 8'h2a, 8'h12,  8'h62, 8'h64, 8'h08, 8'h13, 8'h23,
    8'h36, 8'h49, 8'h55, 8'h22, 8'h50,  8'h00, 8'h05, 8'h03, 8'h00, 8'h00,
    8'h00, 8'h1c, 8'h22, 8'h41, 8'h00,  8'h00, 8'h41, 8'h22, 8'h1c, 8'h00,
    8'h14, 8'h08, 8'h3e, 8'h08, 8'h14,  8'h08, 8'h08, 8'h3e, 8'h08, 8'h08,
    8'h00, 8'h00, 8'ha0, 8'h60, 8'h00,  8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
    8'h00, 8'h60, 8'h60, 8'h00, 8'h00,  8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
    8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e,  8'h00, 8'h42, 8'h7f, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4b, 8'h31,
    8'h18, 8'h14, 8'h12, 8'h7f, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1e,
    8'h00, 8'h36, 8'h36, 8'h00, 8'h00,  8'h00, 8'h56, 8'h36, 8'h00, 8'h00,
    8'h08, 8'h14, 8'h22, 8'h41, 8'h00,  8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
    8'h00, 8'h41, 8'h22, 8'h14, 8'h08,  8'h02, 8'h01, 8'h51, 8'h09, 8'h06,
    8'h32, 8'h49, 8'h59, 8'h51, 8'h3e,  8'h7c, 8'h12, 8'h11, 8'h12, 8'h7c,
    8'h7f, 8'h49, 8'h49, 8'h49, 8'h36,  8'h3e, 8'h41, 8'h41, 8'h41, 8'h22,
    8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c,  8'h7f, 8'h49, 8'h49, 8'h49, 8'h41,
    8'h7f, 8'h09, 8'h09, 8'h09, 8'h01,  8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a,
    8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f,  8'h00, 8'h41, 8'h7f, 8'h41, 8'h00,
    8'h20, 8'h40, 8'h41, 8'h3f, 8'h01,  8'h7f, 8'h08, 8'h14, 8'h22, 8'h41,
    8'h7f, 8'h40, 8'h40, 8'h40, 8'h40,  8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f,
    8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f,  8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e,
    8'h7f, 8'h09, 8'h09, 8'h09, 8'h06,  8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e,
    8'h7f, 8'h09, 8'h19, 8'h29, 8'h46,  8'h46, 8'h49, 8'h49, 8'h49, 8'h31,
    8'h01, 8'h01, 8'h7f, 8'h01, 8'h01,  8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f,
    8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f,  8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f,
    8'h63, 8'h14, 8'h08, 8'h14, 8'h63,  8'h07, 8'h08, 8'h70, 8'h08, 8'h07,
    8'h61, 8'h51, 8'h49, 8'h45, 8'h43,  8'h00, 8'h7f, 8'h41, 8'h41, 8'h00,
    8'h55, 8'h2a, 8'h55, 8'h2a, 8'h55,  8'h00, 8'h41, 8'h41, 8'h7f, 8'h00,
    8'h04, 8'h02, 8'h01, 8'h02, 8'h04,  8'h40, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h00, 8'h01, 8'h02, 8'h04, 8'h00,  8'h20, 8'h54, 8'h54, 8'h54, 8'h78,
    8'h7f, 8'h48, 8'h44, 8'h44, 8'h38,  8'h38, 8'h44, 8'h44, 8'h44, 8'h20,
    8'h38, 8'h44, 8'h44, 8'h48, 8'h7f,  8'h38, 8'h54, 8'h54, 8'h54, 8'h18,
    8'h08, 8'h7e, 8'h09, 8'h01, 8'h02,  8'h18, 8'ha4, 8'ha4, 8'ha4, 8'h7c,
    8'h7f, 8'h08, 8'h04, 8'h04, 8'h78,  8'h00, 8'h44, 8'h7d, 8'h40, 8'h00,
    8'h40, 8'h80, 8'h84, 8'h7d, 8'h00,  8'h7f, 8'h10, 8'h28, 8'h44, 8'h00,
    8'h00, 8'h41, 8'h7f, 8'h40, 8'h00,  8'h7c, 8'h04, 8'h18, 8'h04, 8'h78,
    8'h7c, 8'h08, 8'h04, 8'h04, 8'h78,  8'h38, 8'h44, 8'h44, 8'h44, 8'h38,
    8'hfc, 8'h24, 8'h24, 8'h24, 8'h18,  8'h18, 8'h24, 8'h24, 8'h18, 8'hfc,
    8'h7c, 8'h08, 8'h04, 8'h04, 8'h08,  8'h48, 8'h54, 8'h54, 8'h54, 8'h20,
    8'h04, 8'h3f, 8'h44, 8'h40, 8'h20,  8'h3c, 8'h40, 8'h40, 8'h20, 8'h7c,
    8'h1c, 8'h20, 8'h40, 8'h20, 8'h1c,  8'h3c, 8'h40, 8'h30, 8'h40, 8'h3c,
    8'h44, 8'h28, 8'h10, 8'h28, 8'h44,  8'h1c, 8'ha0, 8'ha0, 8'ha0, 8'h7c,
    8'h44, 8'h64, 8'h54, 8'h4c, 8'h44
  };

  typedef struct packed {
    logic [7:0] column_byte;
    logic       last;
    logic       unknown_char;
  } column_t;

  logic clk;
  logic rst_n;

  grt_in_if  req_bus ();
  grt_out_if col_bus ();

  glyph_column_text_renderer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (col_bus)
  );

  column_t cols_due [$];
  column_t col_head;
  int      err_count;
  int      requests_sent;
  int      cols_checked;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_left;

  // Clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #(5_000_000);
    $display("timeout with %0d columns still due", cols_due.size());
    $display("glyph_column_text_renderer_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Predict the columns of one request and queue them in order
  function automatic void predict_columns(input logic fn, input logic [7:0] ch,
                                          input logic [15:0] num);
    logic [7:0] codes [DIGIT_SLOTS];
    int         ncodes;
    int         rest;
    int         digit;
    bit         started;
    bit         known;
    int         base;
    column_t    col;
    ncodes  = 0;
    rest    = num;
    started = 1'b0;
    if (fn == FN_CHAR) begin
      codes[0] = ch;
      ncodes   = 1;
    end else begin
      for (int p = 0; p < DIGIT_SLOTS; p++) begin
        digit = rest / DIGIT_WEIGHT[p];
        rest  = rest - digit * DIGIT_WEIGHT[p];
        if (digit != 0 || started || p == DIGIT_SLOTS - 1) begin
          started       = 1'b1;
          codes[ncodes] = 8'(CODE_ZERO + digit);
          ncodes++;
        end
      end
    end
    for (int g = 0; g < ncodes; g++) begin
      known = (int'(codes[g]) >= CODE_FIRST) && (int'(codes[g]) <= CODE_LAST);
      base  = known ? (int'(codes[g]) - CODE_FIRST) * FONT_WIDTH : 0;
      for (int c = 0; c < CELL_COLS; c++) begin
        col.column_byte  = (known && c > 0) ? GLYPH_COLS[base + c - 1] : 8'h00;
        col.last         = (g == ncodes - 1) && (c == CELL_COLS - 1);
        col.unknown_char = !known;
        cols_due.push_back(col);
      end
    end
  endfunction

  // Offer one request after a random gap, hold it until accepted
  task automatic send_request(input logic fn, input logic [7:0] ch, input logic [15:0] num);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid     <= 1'b0;
      req_bus.func      <= 1'($urandom);
      req_bus.char_code <= 8'($urandom);
      req_bus.number    <= 16'($urandom);
      @(negedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.func      <= fn;
    req_bus.char_code <= ch;
    req_bus.number    <= num;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predict_columns(fn, ch, num);
    requests_sent++;
  endtask

  // Drop valid and wait until every predicted column has come out
  task automatic wait_for_columns();
    int waited;
    waited = 0;
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (cols_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      col_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      col_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each column transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && col_bus.valid && col_bus.ready) begin
      if (cols_due.size() == 0) begin
        report_mismatch($sformatf("unexpected column 0x%02h last=%0b unknown=%0b",
                                  col_bus.column_byte, col_bus.last, col_bus.unknown_char));
      end else begin
        col_head = cols_due.pop_front();
        if (col_bus.column_byte !== col_head.column_byte) begin
          report_mismatch($sformatf("column_byte got 0x%02h want 0x%02h",
                                    col_bus.column_byte, col_head.column_byte));
        end
        if (col_bus.last !== col_head.last) begin
          report_mismatch($sformatf("last got %0b want %0b", col_bus.last, col_head.last));
        end
        if (col_bus.unknown_char !== col_head.unknown_char) begin
          report_mismatch($sformatf("unknown_char got %0b want %0b",
                                    col_bus.unknown_char, col_head.unknown_char));
        end
        cols_checked++;
      end
    end
  end

  // Printable codes at both ends of the font and a few in between
  task automatic test_font_edges();
    send_request(FN_CHAR, 8'd32, 16'hffff);
    send_request(FN_CHAR, 8'd122, 16'h0000);
    send_request(FN_CHAR, 8'd33, 16'h5a5a);
    send_request(FN_CHAR, 8'd121, 16'ha5a5);
    send_request(FN_CHAR, 8'd48, 16'd0);
    send_request(FN_CHAR, 8'd65, 16'd12345);
    send_request(FN_CHAR, 8'd103, 16'd7);
    wait_for_columns();
  endtask

  // Codes outside the font give blank flagged cells
  task automatic test_unknown_codes();
    send_request(FN_CHAR, 8'd0, 16'h0000);
    send_request(FN_CHAR, 8'd31, 16'hffff);
    send_request(FN_CHAR, 8'd123, 16'd1);
    send_request(FN_CHAR, 8'd128, 16'd500);
    send_request(FN_CHAR, 8'd255, 16'hffff);
    wait_for_columns();
  endtask

  // Zero, digit-count boundaries and the largest value; char_code is ignored here
  task automatic test_number_edges();
    send_request(FN_NUMBER, 8'hff, 16'd0);
    send_request(FN_NUMBER, 8'h00, 16'd65535);
    send_request(FN_NUMBER, 8'h10, 16'd9);
    send_request(FN_NUMBER, 8'h7b, 16'd10);
    send_request(FN_NUMBER, 8'h41, 16'd99);
    send_request(FN_NUMBER, 8'h00, 16'd100);
    send_request(FN_NUMBER, 8'hff, 16'd1000);
    send_request(FN_NUMBER, 8'h20, 16'd9999);
    send_request(FN_NUMBER, 8'h7a, 16'd10000);
    send_request(FN_NUMBER, 8'h80, 16'd40302);
    send_request(FN_NUMBER, 8'h01, 16'd1);
    wait_for_columns();
  endtask

  // Mixed random traffic: printable and random characters and numbers of 1 to 5 digits
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    int          pick;
    int          ndig;
    int          lo;
    int          hi;
    logic [7:0]  ch;
    logic [15:0] num;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      ch   = 8'($urandom);
      num  = 16'($urandom);
      if (pick < 40) begin
        ch = 8'($urandom_range(CODE_LAST, CODE_FIRST));
        send_request(FN_CHAR, ch, num);
      end else if (pick < 52) begin
        send_request(FN_CHAR, ch, num);
      end else begin
        ndig = $urandom_range(5, 1);
        lo   = (ndig == 1) ? 0 : DIGIT_WEIGHT[DIGIT_SLOTS - ndig];
        hi   = (ndig == 5) ? 65535 : DIGIT_WEIGHT[DIGIT_SLOTS - ndig - 1] - 1;
        num  = 16'($urandom_range(hi, lo));
        send_request(FN_NUMBER, ch, num);
      end
    end
    wait_for_columns();
  endtask

  // Hold the receiver off for a long stretch while requests keep coming
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = 300;
    for (int k = 0; k < 20; k++) begin
      if (k % 2 == 0) begin
        send_request(FN_NUMBER, 8'($urandom), 16'($urandom_range(65535, 10000)));
      end else begin
        send_request(FN_CHAR, 8'($urandom_range(CODE_LAST, CODE_FIRST)), 16'($urandom));
      end
    end
    wait_for_columns();
  endtask

  initial begin
    err_count     = 0;
    requests_sent = 0;
    cols_checked  = 0;
    send_idle_pct = 38;
    recv_idle_pct = 58;
    hold_left     = 0;
    rst_n             = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.func      = FN_CHAR;
    req_bus.char_code = 8'h00;
    req_bus.number    = 16'h0000;
    col_bus.ready     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_font_edges();
    test_unknown_codes();
    test_number_edges();
    test_random_traffic(140, 38, 58);
    test_random_traffic(140, 58, 38);
    test_output_hold();
    test_random_traffic(140, 0, 0);

    if (cols_due.size() != 0) begin
      report_mismatch($sformatf("%0d predicted columns never arrived", cols_due.size()));
    end
    $display("covered %0d requests (characters in and out of the font, numbers of 1 to 5 digits)",
             requests_sent);
    $display("checked %0d columns under sender and receiver stalls and a long output hold",
             cols_checked);
    if (err_count == 0) begin
      $display("glyph_column_text_renderer_tb passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("glyph_column_text_renderer_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/grt_pkg.sv
rtl/grt_if.sv
rtl/grt_font_rom.sv
rtl/glyph_column_text_renderer.sv
tb/glyph_column_text_renderer_tb.sv
